[hw/rtl/tcp_segment_reassembly_tracker_macros.svh]
// assertion macros for the segment reassembly tracker
// used by the top level; expects clk and arst_n in the including scope
`ifndef TCP_SEGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`define TCP_SEGMENT_REASSEMBLY_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF
// property holds at every edge outside reset
`define SRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRT_ASSERT(lbl, prop, msg)
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/srt_pkg.sv]
// shared types and constants of the segment reassembly tracker
// no dependencies
`default_nettype none

package srt_pkg;

	// field widths
	localparam int OFF_W   = 32;
	localparam int LEN_W   = 16;
	localparam int TAG_W   = 8;
	localparam int BYTES_W = 21;
	localparam int KIND_W  = 2;

	// stream word widths
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 112;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [0:0] REG_START_OFFSET = 1'b0;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CACHED   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STALE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_SCAN_CHAIN,
		ST_HIT_WAIT,
		ST_SCAN_INSERT,
		ST_INSERT,
		ST_FINISH
	} srt_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_seg;
		logic classify;
		logic scan_start;
		logic scan_run;
		logic chain_key;
		logic release_hit;
		logic insert;
		logic push;
		logic push_last;
	} srt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic eq;
		logic gt;
		logic hit;
		logic scan_end;
		logic out_free;
	} srt_sts_t;

endpackage

`default_nettype wire

[hw/rtl/tcp_segment_reassembly_tracker.sv]
// channel   dir  handshake                 payload
// s_axis    in   tvalid/tready             tdata: seg_offset, seg_length, buffer_tag
// m_axis    out  tvalid/tready, tlast      tdata: result fields, tuser: outcome
// apb       in   psel/penable/pwrite       start_offset at byte address 0
//
// one segment at a time, by a scan that reads one cache entry per cycle; a stale
// segment is answered without a scan, and after each chained release the scan starts
// again once the pending word has been sent to the output register
// reset clears the expected offset and all entry valid bits at once
// a stalled output word holds the block before it sends its next word
//
// top level of the segment reassembly tracker
// depends on srt_pkg, srt_ctrl, srt_dpath and the assertion macro header
`default_nettype none
`include "tcp_segment_reassembly_tracker_macros.svh"

module tcp_segment_reassembly_tracker #(
	parameter int CACHE_DEPTH = 16,
	parameter int TAG_BITS    = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [srt_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [srt_pkg::DATA_W-1:0]         pwdata,
	output logic      [srt_pkg::DATA_W-1:0]         prdata,
	output logic                                    pready,
	// segment descriptors
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// seg_offset [31:0], seg_length [47:32], buffer_tag [55:48]
	input  wire logic [srt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// results
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// rel_offset [31:0], rel_length [47:32], rel_tag [55:48],
	// bytes_done [76:56], expected_now [108:77], zero [111:109]
	output logic      [srt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// outcome [1:0]
	output logic      [srt_pkg::KIND_W-1:0]         m_axis_tuser,
	output logic                                    m_axis_tlast
);

	import srt_pkg::*;

	localparam int PAD_W = OUT_DATA_W - (2 * OFF_W + LEN_W + TAG_W + BYTES_W);

	srt_cmd_t           cmd;
	srt_sts_t           sts;
	logic [OFF_W-1:0]   start_offset_q;
	logic               cfg_write;
	logic               cfg_hit;
	logic [OFF_W-1:0]   out_offset;
	logic [LEN_W-1:0]   out_length;
	logic [TAG_W-1:0]   out_tag;
	logic [BYTES_W-1:0] out_bytes;
	logic [OFF_W-1:0]   out_expected;

	// register decode
	assign pready    = 1'b1;
	assign cfg_hit   = (paddr[ADDR_W-1:2] == REG_START_OFFSET);
	assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_offset_q <= '0;
		end else if (cfg_write) begin
			start_offset_q <= pwdata;
		end
	end

	assign prdata = cfg_hit ? start_offset_q : '0;

	srt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srt_dpath #(
		.CACHE_DEPTH (CACHE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_offset    (s_axis_tdata[OFF_W-1:0]),
		.in_length    (s_axis_tdata[OFF_W+LEN_W-1:OFF_W]),
		.in_tag       (s_axis_tdata[OFF_W+LEN_W+TAG_W-1:OFF_W+LEN_W]),
		.cfg_load     (cfg_write),
		.cfg_value    (pwdata),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_kind     (m_axis_tuser),
		.out_offset   (out_offset),
		.out_length   (out_length),
		.out_tag      (out_tag),
		.out_bytes    (out_bytes),
		.out_expected (out_expected),
		.out_last     (m_axis_tlast)
	);

	// result word packing
	assign m_axis_tdata = {{PAD_W{1'b0}}, out_expected, out_bytes, out_tag, out_length,
		out_offset};

	// checks
	`SRT_ASSERT_NEXT(a_one_segment, s_axis_tvalid && s_axis_tready, !s_axis_tready, "overlap")
	`SRT_ASSERT(a_push_free, !cmd.push || sts.out_free, "result word overwritten before taken")
	`SRT_ASSERT(a_hit_or_end, !(sts.hit && sts.scan_end), "scan reports hit and end together")

endmodule

`default_nettype wire

[hw/rtl/srt_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/srt_ctrl.sv]
// controller state machine of the segment reassembly tracker
// depends on srt_pkg
`default_nettype none

module srt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire srt_pkg::srt_sts_t sts,
	output srt_pkg::srt_cmd_t      cmd
);

	import srt_pkg::*;

	srt_state_t state_q;
	srt_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_seg = 1'b1;
					state_d      = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				cmd.classify = 1'b1;
				if (sts.eq) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN_CHAIN;
				end else if (sts.gt) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN_INSERT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			// look for a cached segment at the expected offset
			ST_SCAN_CHAIN: begin
				cmd.chain_key = 1'b1;
				if (sts.hit) begin
					state_d = ST_HIT_WAIT;
				end else if (sts.scan_end) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			// send the pending word and release the found entry
			ST_HIT_WAIT: begin
				if (sts.out_free) begin
					cmd.push        = 1'b1;
					cmd.release_hit = 1'b1;
					cmd.scan_start  = 1'b1;
					state_d         = ST_SCAN_CHAIN;
				end
			end
			// look for a duplicate offset and a free slot
			ST_SCAN_INSERT: begin
				if (sts.hit || sts.scan_end) begin
					state_d = ST_INSERT;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/srt_dpath.sv]
// datapath of the segment reassembly tracker: offsets, cache, output register
// depends on srt_pkg and srt_ram
`default_nettype none

module srt_dpath #(
	parameter int CACHE_DEPTH = 16,
	parameter int TAG_BITS    = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire srt_pkg::srt_cmd_t             cmd,
	output srt_pkg::srt_sts_t                  sts,
	input  wire logic [srt_pkg::OFF_W-1:0]     in_offset,
	input  wire logic [srt_pkg::LEN_W-1:0]     in_length,
	input  wire logic [srt_pkg::TAG_W-1:0]     in_tag,
	input  wire logic                          cfg_load,
	input  wire logic [srt_pkg::OFF_W-1:0]     cfg_value,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic      [srt_pkg::KIND_W-1:0]    out_kind,
	output logic      [srt_pkg::OFF_W-1:0]     out_offset,
	output logic      [srt_pkg::LEN_W-1:0]     out_length,
	output logic      [srt_pkg::TAG_W-1:0]     out_tag,
	output logic      [srt_pkg::BYTES_W-1:0]   out_bytes,
	output logic      [srt_pkg::OFF_W-1:0]     out_expected,
	output logic                               out_last
);

	import srt_pkg::*;

	localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int CW = $clog2(CACHE_DEPTH + 1);
	localparam int EW = OFF_W + LEN_W + TAG_BITS;
	localparam int TW = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;
	localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((32'd1 << TAG_BITS) - 32'd1);

	// segment being worked on
	logic [OFF_W-1:0]   seg_off_q;
	logic [LEN_W-1:0]   seg_len_q;
	logic [TAG_W-1:0]   seg_tag_q;
	logic [OFF_W-1:0]   expected_q;
	logic [BYTES_W-1:0] total_q;

	// pending result word
	logic [KIND_W-1:0]  pend_kind_q;
	logic [OFF_W-1:0]   pend_off_q;
	logic [LEN_W-1:0]   pend_len_q;
	logic [TAG_W-1:0]   pend_tag_q;
	logic [BYTES_W-1:0] pend_bytes_q;
	logic [OFF_W-1:0]   pend_exp_q;

	// cache valid bits and scan
	logic [CACHE_DEPTH-1:0] valid_q;
	logic [CW-1:0]          scan_idx_q;
	logic                   rd_valid_s1;
	logic [AW-1:0]          addr_s1;
	logic                   hit_q;
	logic [AW-1:0]          hit_idx_q;
	logic [OFF_W-1:0]       hit_off_q;
	logic [LEN_W-1:0]       hit_len_q;
	logic [TAG_W-1:0]       hit_tag_q;
	logic                   free_found_q;
	logic [AW-1:0]          free_idx_q;

	// output register
	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [OFF_W-1:0]   out_off_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [BYTES_W-1:0] out_bytes_q;
	logic [OFF_W-1:0]   out_exp_q;
	logic               out_last_q;

	logic                issue;
	logic [EW-1:0]       rdata;
	logic [OFF_W-1:0]    rd_off;
	logic [LEN_W-1:0]    rd_len;
	logic [TAG_BITS-1:0] rd_tag;
	logic [TW-1:0]       rd_tag_ext;
	logic [TW-1:0]       seg_tag_ext;
	logic [OFF_W-1:0]    key;
	logic                hit;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [EW-1:0]       wdata;
	logic [OFF_W-1:0]    seg_end;
	logic [OFF_W-1:0]    rel_exp;
	logic [BYTES_W-1:0]  rel_total;
	logic                out_free;

	// scan address issue and entry compare
	assign issue      = cmd.scan_run && (scan_idx_q < CW'(CACHE_DEPTH));
	assign rd_off     = rdata[OFF_W-1:0];
	assign rd_len     = rdata[OFF_W+LEN_W-1:OFF_W];
	assign rd_tag     = rdata[EW-1:OFF_W+LEN_W];
	assign rd_tag_ext = TW'(rd_tag);
	assign key        = cmd.chain_key ? expected_q : seg_off_q;
	assign hit        = rd_valid_s1 && valid_q[addr_s1] && (rd_off == key);

	// arithmetic on offsets and byte total
	assign seg_end   = seg_off_q + OFF_W'(seg_len_q);
	assign rel_exp   = expected_q + OFF_W'(hit_len_q);
	assign rel_total = total_q + BYTES_W'(hit_len_q);

	// cache write on insert: duplicate slot first, else first free slot
	assign seg_tag_ext = TW'(seg_tag_q);
	assign we          = cmd.insert && (hit_q || free_found_q);
	assign waddr       = hit_q ? hit_idx_q : free_idx_q;
	assign wdata       = {seg_tag_ext[TAG_BITS-1:0], seg_len_q, seg_off_q};

	assign out_free = !out_valid_q || out_ready;

	// status to controller
	always_comb begin
		sts.eq       = (seg_off_q == expected_q);
		sts.gt       = (seg_off_q > expected_q);
		sts.hit      = hit;
		sts.scan_end = rd_valid_s1 && !hit && (addr_s1 == AW'(CACHE_DEPTH - 1));
		sts.out_free = out_free;
	end

	srt_ram #(
		.WIDTH (EW),
		.DEPTH (CACHE_DEPTH)
	) u_cache (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (scan_idx_q[AW-1:0]),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q   <= '0;
			valid_q      <= '0;
			scan_idx_q   <= '0;
			rd_valid_s1  <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// expected offset
			if (cfg_load) begin
				expected_q <= cfg_value;
			end else if (cmd.classify && sts.eq) begin
				expected_q <= seg_end;
			end else if (cmd.release_hit) begin
				expected_q <= rel_exp;
			end

			// entry valid bits
			if (cmd.release_hit) begin
				valid_q[hit_idx_q] <= 1'b0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end

			// scan counter and read stage
			if (cmd.scan_start) begin
				scan_idx_q   <= '0;
				rd_valid_s1  <= 1'b0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
				rd_valid_s1 <= issue;
				if (hit) begin
					hit_q <= 1'b1;
				end
				if (rd_valid_s1 && !valid_q[addr_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end

			// output word handshake
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_seg) begin
			seg_off_q <= in_offset;
			seg_len_q <= in_length;
			seg_tag_q <= in_tag & TAG_MASK;
		end

		addr_s1 <= scan_idx_q[AW-1:0];

		// found entry and first free slot
		if (!cmd.scan_start && hit) begin
			hit_idx_q <= addr_s1;
			hit_off_q <= rd_off;
			hit_len_q <= rd_len;
			hit_tag_q <= rd_tag_ext[TAG_W-1:0];
		end
		if (!cmd.scan_start && rd_valid_s1 && !valid_q[addr_s1] && !free_found_q) begin
			free_idx_q <= addr_s1;
		end

		// running released byte total
		if (cmd.classify) begin
			total_q <= BYTES_W'(seg_len_q);
		end else if (cmd.release_hit) begin
			total_q <= rel_total;
		end

		// pending result word
		if (cmd.classify) begin
			pend_off_q <= seg_off_q;
			pend_len_q <= seg_len_q;
			pend_tag_q <= seg_tag_q;
			if (sts.eq) begin
				pend_kind_q  <= KIND_RELEASED;
				pend_bytes_q <= BYTES_W'(seg_len_q);
				pend_exp_q   <= seg_end;
			end else if (sts.gt) begin
				pend_kind_q  <= KIND_CACHED;
				pend_bytes_q <= BYTES_W'(seg_len_q);
				pend_exp_q   <= expected_q;
			end else begin
				pend_kind_q  <= KIND_STALE;
				pend_bytes_q <= '0;
				pend_exp_q   <= expected_q;
			end
		end else if (cmd.release_hit) begin
			pend_kind_q  <= KIND_RELEASED;
			pend_off_q   <= hit_off_q;
			pend_len_q   <= hit_len_q;
			pend_tag_q   <= hit_tag_q;
			pend_bytes_q <= rel_total;
			pend_exp_q   <= rel_exp;
		end else if (cmd.insert && !we) begin
			pend_kind_q  <= KIND_DROPPED;
			pend_bytes_q <= '0;
		end

		// output word
		if (cmd.push) begin
			out_kind_q  <= pend_kind_q;
			out_off_q   <= pend_off_q;
			out_len_q   <= pend_len_q;
			out_tag_q   <= pend_tag_q;
			out_bytes_q <= pend_bytes_q;
			out_exp_q   <= pend_exp_q;
			out_last_q  <= cmd.push_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = out_kind_q;
	assign out_offset   = out_off_q;
	assign out_length   = out_len_q;
	assign out_tag      = out_tag_q;
	assign out_bytes    = out_bytes_q;
	assign out_expected = out_exp_q;
	assign out_last     = out_last_q;

endmodule

`default_nettype wire
